// ===== sv/ffsa_pkg.sv =====
package ffsa_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    localparam int STATUS_W = 3;

endpackage

// ===== sv/ffsa_ram.sv =====
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/first_fit_segment_allocator_unit.sv =====
// First-fit segment allocator.
// Input channel s_*: one request per transaction, s_tuser holds cmd (allocate
// or release), tdata holds req_size and req_address. Output channel m_*: one
// result per request, tdata holds block_address and status.
// The segment table (start, length, used mark) lives in one RAM with a
// registered read port. A request walks the table one entry per cycle until
// the first matching entry, reads its successor, then opens or closes a slot
// by moving the later entries one per cycle, and finishes with up to two
// write-backs. The walk and the shift over the single RAM read port bound the
// time a request takes. One request is in work at a time; the next one is
// taken once the result is loaded and the block is back in IDLE.
// After reset the block writes the initial free segment covering the pool in
// its INIT state, then accepts requests.
// A finished result is held in the output register until the receiver takes
// it; a new request may be accepted meanwhile, but its own result waits
// until the register is free.
module first_fit_segment_allocator_unit #(
    parameter int POOL_BYTES   = 4096,
    parameter int MAX_SEGMENTS = 64,
    localparam int AW    = $clog2(POOL_BYTES),
    localparam int LW    = AW + 1,
    localparam int IN_W  = ((LW + AW + 7) / 8) * 8,
    localparam int OUT_W = ((AW + ffsa_pkg::STATUS_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // req_size, req_address
    input  logic             s_tuser,   // cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // block_address, status
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = AW + LW + 1;

    typedef enum logic [2:0] {
        INIT, IDLE, SCAN, NEXTRD, DECIDE, SHIFT, WRA, DONE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic            cmd_reg;
    logic [LW-1:0]   size_reg;
    logic [AW-1:0]   addr_reg;
    logic [CW-1:0]   k_reg;
    logic            pend_reg;
    logic [CW-1:0]   pidx_reg;
    logic [CW-1:0]   i_reg;
    logic [EW-1:0]   cur_reg;
    logic [EW-1:0]   prev_reg;
    logic            prevok_reg;
    logic            nextok_reg;
    logic            up_reg;
    logic [1:0]      dist_reg;
    logic [CW-1:0]   sk_reg;
    logic [CW-1:0]   rem_reg;
    logic            spend_reg;
    logic [CW-1:0]   sdst_reg;
    logic [IW-1:0]   wa_addr_reg;
    logic [EW-1:0]   wa_data_reg;
    logic [IW-1:0]   wb_addr_reg;
    logic [EW-1:0]   wb_data_reg;
    logic            two_reg;
    logic            second_reg;
    ffsa_pkg::status_t st_reg;
    logic [AW-1:0]   baddr_reg;
    logic            mvalid_reg;
    logic [AW-1:0]   mbaddr_reg;
    ffsa_pkg::status_t mst_reg;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;
    logic [IW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data;

    logic [AW-1:0]   e_start, c_start, p_start;
    logic [LW-1:0]   e_len, c_len, p_len;
    logic            e_used, p_used;
    logic            match;
    logic            pf, nf, full;

    assign e_start = rd_data[AW-1:0];
    assign e_len   = rd_data[AW+LW-1:AW];
    assign e_used  = rd_data[EW-1];
    assign c_start = cur_reg[AW-1:0];
    assign c_len   = cur_reg[AW+LW-1:AW];
    assign p_start = prev_reg[AW-1:0];
    assign p_len   = prev_reg[AW+LW-1:AW];
    assign p_used  = prev_reg[EW-1];

    assign match = (cmd_reg == ffsa_pkg::CMD_ALLOC) ? (!e_used && e_len >= size_reg)
                                                    : (e_used && e_start == addr_reg);
    assign pf   = prevok_reg && !p_used;
    assign nf   = nextok_reg && !e_used;
    assign full = count_reg >= CW'(MAX_SEGMENTS);

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read address and write port steering.
    always_comb begin
        rd_addr = k_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = wa_addr_reg;
        wr_data = wa_data_reg;
        case (state_reg)
            INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b0, LW'(POOL_BYTES), AW'(0)};
            end
            NEXTRD: rd_addr = IW'(i_reg + CW'(1));
            SHIFT: begin
                rd_addr = sk_reg[IW-1:0];
                wr_en   = spend_reg;
                wr_addr = sdst_reg[IW-1:0];
                wr_data = rd_data;
            end
            WRA: begin
                wr_en   = 1'b1;
                wr_addr = second_reg ? wb_addr_reg : wa_addr_reg;
                wr_data = second_reg ? wb_data_reg : wa_data_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_W'({mst_reg, mbaddr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= INIT;
            count_reg  <= CW'(1);
            mvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            spend_reg  <= 1'b0;
        end else begin
            // drop the taken result; DONE reloads the register itself
            if (mvalid_reg && m_tready && state_reg != DONE) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                INIT: state_reg <= IDLE;
                IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg    <= s_tuser;
                        size_reg   <= s_tdata[LW-1:0];
                        addr_reg   <= s_tdata[LW+AW-1:LW];
                        k_reg      <= '0;
                        pend_reg   <= 1'b0;
                        prevok_reg <= 1'b0;
                        baddr_reg  <= '0;
                        // zero-size allocate never fits
                        if (s_tuser == ffsa_pkg::CMD_ALLOC && s_tdata[LW-1:0] == '0) begin
                            st_reg    <= ffsa_pkg::ST_NO_FIT;
                            state_reg <= DONE;
                        end else begin
                            state_reg <= SCAN;
                        end
                    end
                end
                SCAN: begin
                    if (pend_reg && match) begin
                        i_reg     <= pidx_reg;
                        cur_reg   <= rd_data;
                        state_reg <= NEXTRD;
                    end else if (k_reg >= count_reg) begin
                        st_reg    <= (cmd_reg == ffsa_pkg::CMD_ALLOC) ? ffsa_pkg::ST_NO_FIT
                                                                      : ffsa_pkg::ST_NOT_FOUND;
                        state_reg <= DONE;
                    end else begin
                        if (pend_reg) begin
                            prev_reg   <= rd_data;
                            prevok_reg <= 1'b1;
                        end
                        pend_reg <= 1'b1;
                        pidx_reg <= k_reg;
                        k_reg    <= k_reg + CW'(1);
                    end
                end
                NEXTRD: begin
                    nextok_reg <= (i_reg + CW'(1)) < count_reg;
                    state_reg  <= DECIDE;
                end
                DECIDE: begin
                    // defaults: no move, one write-back
                    rem_reg    <= '0;
                    spend_reg  <= 1'b0;
                    two_reg    <= 1'b0;
                    second_reg <= 1'b0;
                    st_reg     <= ffsa_pkg::ST_OK;
                    state_reg  <= SHIFT;
                    if (cmd_reg == ffsa_pkg::CMD_ALLOC) begin
                        if (c_len == size_reg) begin
                            wa_addr_reg <= i_reg[IW-1:0];
                            wa_data_reg <= {1'b1, c_len, c_start};
                            baddr_reg   <= c_start;
                        end else if (full) begin
                            st_reg    <= ffsa_pkg::ST_FULL;
                            state_reg <= DONE;
                        end else begin
                            up_reg      <= 1'b1;
                            sk_reg      <= count_reg - CW'(1);
                            rem_reg     <= count_reg - i_reg - CW'(1);
                            wa_addr_reg <= IW'(i_reg + CW'(1));
                            wa_data_reg <= {1'b0, c_len - size_reg, c_start + AW'(size_reg)};
                            wb_addr_reg <= i_reg[IW-1:0];
                            wb_data_reg <= {1'b1, size_reg, c_start};
                            two_reg     <= 1'b1;
                            count_reg   <= count_reg + CW'(1);
                            baddr_reg   <= c_start;
                        end
                    end else if (size_reg == '0 || size_reg > c_len) begin
                        st_reg    <= ffsa_pkg::ST_TOO_LARGE;
                        state_reg <= DONE;
                    end else if (size_reg == c_len) begin
                        up_reg <= 1'b0;
                        if (pf && nf) begin
                            wa_addr_reg <= IW'(i_reg - CW'(1));
                            wa_data_reg <= {1'b0, p_len + c_len + e_len, p_start};
                            dist_reg    <= 2'd2;
                            sk_reg      <= i_reg + CW'(2);
                            rem_reg     <= count_reg - i_reg - CW'(2);
                            count_reg   <= count_reg - CW'(2);
                        end else if (pf) begin
                            wa_addr_reg <= IW'(i_reg - CW'(1));
                            wa_data_reg <= {1'b0, p_len + c_len, p_start};
                            dist_reg    <= 2'd1;
                            sk_reg      <= i_reg + CW'(1);
                            rem_reg     <= count_reg - i_reg - CW'(1);
                            count_reg   <= count_reg - CW'(1);
                        end else if (nf) begin
                            wa_addr_reg <= i_reg[IW-1:0];
                            wa_data_reg <= {1'b0, c_len + e_len, c_start};
                            dist_reg    <= 2'd1;
                            sk_reg      <= i_reg + CW'(2);
                            rem_reg     <= count_reg - i_reg - CW'(2);
                            count_reg   <= count_reg - CW'(1);
                        end else begin
                            wa_addr_reg <= i_reg[IW-1:0];
                            wa_data_reg <= {1'b0, c_len, c_start};
                        end
                    end else if (pf) begin
                        // leading bytes go to the free predecessor
                        wa_addr_reg <= IW'(i_reg - CW'(1));
                        wa_data_reg <= {1'b0, p_len + size_reg, p_start};
                        wb_addr_reg <= i_reg[IW-1:0];
                        wb_data_reg <= {1'b1, c_len - size_reg, c_start + AW'(size_reg)};
                        two_reg     <= 1'b1;
                    end else if (full) begin
                        st_reg    <= ffsa_pkg::ST_FULL;
                        state_reg <= DONE;
                    end else begin
                        up_reg      <= 1'b1;
                        sk_reg      <= count_reg - CW'(1);
                        rem_reg     <= count_reg - i_reg;
                        wa_addr_reg <= i_reg[IW-1:0];
                        wa_data_reg <= {1'b0, size_reg, c_start};
                        wb_addr_reg <= IW'(i_reg + CW'(1));
                        wb_data_reg <= {1'b1, c_len - size_reg, c_start + AW'(size_reg)};
                        two_reg     <= 1'b1;
                        count_reg   <= count_reg + CW'(1);
                    end
                end
                SHIFT: begin
                    // read one entry per cycle, write it to its new slot next cycle
                    if (rem_reg != '0) begin
                        rem_reg   <= rem_reg - CW'(1);
                        spend_reg <= 1'b1;
                        sdst_reg  <= up_reg ? sk_reg + CW'(1) : sk_reg - CW'(dist_reg);
                        sk_reg    <= up_reg ? sk_reg - CW'(1) : sk_reg + CW'(1);
                    end else begin
                        spend_reg <= 1'b0;
                        if (!spend_reg) begin
                            state_reg <= WRA;
                        end
                    end
                end
                WRA: begin
                    if (two_reg && !second_reg) begin
                        second_reg <= 1'b1;
                    end else begin
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    // hold the result until the output register is free
                    if (!mvalid_reg || m_tready) begin
                        mvalid_reg <= 1'b1;
                        mbaddr_reg <= (st_reg == ffsa_pkg::ST_OK) ? baddr_reg : '0;
                        mst_reg    <= st_reg;
                        state_reg  <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ===== tb/tb_first_fit_segment_allocator_unit.sv =====
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator_unit;

    localparam int POOL      = 4096;
    localparam int MAX_SEG   = 64;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 16;
    localparam int N_RANDOM  = 1030;
    localparam int EXP_DEPTH = 2048;
    localparam int LIVE_MAX  = 2048;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    always #1 aclk = ~aclk;

    first_fit_segment_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // req_size [12:0], req_address [24:13]
        .s_tuser  (s_tuser),     // cmd
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)      // block_address [11:0], status [14:12]
    );

    typedef struct packed {
        logic [11:0]       addr;
        ffsa_pkg::status_t status;
    } alloc_result_t;

    // Shadow segment table
    logic [11:0] seg_base [MAX_SEG];
    logic [12:0] seg_len  [MAX_SEG];
    logic        seg_busy [MAX_SEG];
    int          seg_num;

    // expected results in request order
    alloc_result_t exp_fifo [EXP_DEPTH];
    int            exp_wr = 0;
    int            exp_rd = 0;
    // addresses we believe are allocated
    logic [11:0]   live_addr [LIVE_MAX];
    int            live_cnt = 0;
    int            errors = 0;

    // Directed table: cmd, size, address, typed expectation (or predictor)
    typedef struct {
        ffsa_pkg::cmd_t    cmd;
        logic [12:0]       size;
        logic [11:0]       addr;
        bit                typed;
        logic [11:0]       exp_addr;
        ffsa_pkg::status_t exp_status;
    } dir_row_t;

    dir_row_t dir_rows [21] = '{
        '{ffsa_pkg::CMD_ALLOC,   13'd0,    12'd0,   1, 12'd0,   ffsa_pkg::ST_NO_FIT},
        '{ffsa_pkg::CMD_RELEASE, 13'd16,   12'd0,   1, 12'd0,   ffsa_pkg::ST_NOT_FOUND},
        '{ffsa_pkg::CMD_ALLOC,   13'd4097, 12'hFFF, 1, 12'd0,   ffsa_pkg::ST_NO_FIT},
        '{ffsa_pkg::CMD_ALLOC,   13'd8191, 12'd0,   1, 12'd0,   ffsa_pkg::ST_NO_FIT},
        '{ffsa_pkg::CMD_ALLOC,   13'd4096, 12'd0,   1, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_ALLOC,   13'd1,    12'd0,   1, 12'd0,   ffsa_pkg::ST_NO_FIT},
        '{ffsa_pkg::CMD_RELEASE, 13'd0,    12'd0,   1, 12'd0,   ffsa_pkg::ST_TOO_LARGE},
        '{ffsa_pkg::CMD_RELEASE, 13'd4097, 12'd0,   1, 12'd0,   ffsa_pkg::ST_TOO_LARGE},
        '{ffsa_pkg::CMD_RELEASE, 13'd4096, 12'd0,   1, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_ALLOC,   13'd100,  12'd0,   1, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_ALLOC,   13'd200,  12'd0,   1, 12'd100, ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_ALLOC,   13'd300,  12'd0,   1, 12'd300, ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd50,   12'd0,   0, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd20,   12'd50,  0, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd200,  12'd100, 0, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd1,    12'd150, 1, 12'd0,   ffsa_pkg::ST_NOT_FOUND},
        '{ffsa_pkg::CMD_ALLOC,   13'd7,    12'hFFF, 0, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd300,  12'd300, 0, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd30,   12'd70,  0, 12'd0,   ffsa_pkg::ST_OK},
        '{ffsa_pkg::CMD_RELEASE, 13'd8191, 12'h555, 1, 12'd0,   ffsa_pkg::ST_NOT_FOUND},
        '{ffsa_pkg::CMD_ALLOC,   13'd5000, 12'hAAA, 1, 12'd0,   ffsa_pkg::ST_NO_FIT}
    };

    function automatic void reset_table();
        for (int k = 0; k < MAX_SEG; k++) begin
            seg_base[k] = '0;
            seg_len[k]  = '0;
            seg_busy[k] = 1'b0;
        end
        seg_len[0] = 13'(POOL);
        seg_num    = 1;
    endfunction

    function automatic void open_entry(int pos);
        for (int k = seg_num; k > pos; k--) begin
            seg_base[k] = seg_base[k-1];
            seg_len[k]  = seg_len[k-1];
            seg_busy[k] = seg_busy[k-1];
        end
        seg_num++;
    endfunction

    function automatic void close_entry(int pos);
        for (int k = pos; k + 1 < seg_num; k++) begin
            seg_base[k] = seg_base[k+1];
            seg_len[k]  = seg_len[k+1];
            seg_busy[k] = seg_busy[k+1];
        end
        seg_num--;
        seg_base[seg_num] = '0;
        seg_len[seg_num]  = '0;
        seg_busy[seg_num] = 1'b0;
    endfunction

    // Apply one request to the shadow table and return what the block answers
    function automatic alloc_result_t predict_request(ffsa_pkg::cmd_t cmd,
                                                      logic [12:0] size,
                                                      logic [11:0] addr);
        alloc_result_t r;
        int i;
        r.addr   = '0;
        r.status = ffsa_pkg::ST_OK;
        if (cmd == ffsa_pkg::CMD_ALLOC) begin
            if (size == 0) begin
                r.status = ffsa_pkg::ST_NO_FIT;
                return r;
            end
            for (i = 0; i < seg_num; i++)
                if (!seg_busy[i] && seg_len[i] >= size) break;
            if (i >= seg_num) begin
                r.status = ffsa_pkg::ST_NO_FIT;
                return r;
            end
            if (seg_len[i] != size) begin
                if (seg_num >= MAX_SEG) begin
                    r.status = ffsa_pkg::ST_FULL;
                    return r;
                end
                open_entry(i + 1);
                seg_base[i+1] = seg_base[i] + size[11:0];
                seg_len[i+1]  = seg_len[i] - size;
                seg_busy[i+1] = 1'b0;
                seg_len[i]    = size;
            end
            seg_busy[i] = 1'b1;
            r.addr = seg_base[i];
            return r;
        end
        for (i = 0; i < seg_num; i++)
            if (seg_busy[i] && seg_base[i] == addr) break;
        if (i >= seg_num) begin
            r.status = ffsa_pkg::ST_NOT_FOUND;
            return r;
        end
        if (size == 0 || size > seg_len[i]) begin
            r.status = ffsa_pkg::ST_TOO_LARGE;
            return r;
        end
        if (size == seg_len[i]) begin
            seg_busy[i] = 1'b0;
            if (i > 0 && !seg_busy[i-1]) begin
                seg_len[i-1] += seg_len[i];
                close_entry(i);
                i--;
            end
            if (i + 1 < seg_num && !seg_busy[i+1]) begin
                seg_len[i] += seg_len[i+1];
                close_entry(i + 1);
            end
            return r;
        end
        if (i > 0 && !seg_busy[i-1]) begin
            seg_len[i-1] += size;
            seg_base[i]  += size[11:0];
            seg_len[i]   -= size;
            return r;
        end
        if (seg_num >= MAX_SEG) begin
            r.status = ffsa_pkg::ST_FULL;
            return r;
        end
        open_entry(i);
        seg_len[i]     = size;
        seg_busy[i]    = 1'b0;
        seg_base[i+1] += size[11:0];
        seg_len[i+1]  -= size;
        return r;
    endfunction

    // Drive one request; hold tvalid across back-to-back bursts
    task automatic send_request(ffsa_pkg::cmd_t cmd, logic [12:0] size, logic [11:0] addr,
                                bit typed, alloc_result_t typed_res);
        alloc_result_t p;
        s_tdata  <= {7'd0, addr, size};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = predict_request(cmd, size, addr);
        exp_fifo[exp_wr] = typed ? typed_res : p;
        exp_wr++;
        if (cmd == ffsa_pkg::CMD_ALLOC && p.status == ffsa_pkg::ST_OK) begin
            live_addr[live_cnt] = p.addr;
            live_cnt++;
        end
        // burst with random gaps
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Receiver stall pattern: ready mostly high, with random stalls drawn independently
    always @(posedge aclk) begin
        int ph;
        ph = $urandom_range(0, 15);
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (ph < 10) ? 1'b1 : (ph < 15 ? 1'b0 : ($urandom_range(0, 1) == 1));
    end

    // Compare each result transaction against the oldest expectation
    always @(posedge aclk) begin
        alloc_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.addr   = m_tdata[11:0];
            got.status = ffsa_pkg::status_t'(m_tdata[14:12]);
            if (exp_rd == exp_wr) begin
                $display("%0t unexpected result: expected none, actual addr=%0d status=%0d",
                         $time, got.addr, got.status);
                errors++;
            end else begin
                want = exp_fifo[exp_rd];
                exp_rd++;
                if (got.addr !== want.addr) begin
                    $display("%0t block_address mismatch: expected %0d actual %0d",
                             $time, want.addr, got.addr);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        ffsa_pkg::cmd_t c;
        logic [12:0]    sz;
        logic [11:0]    ad;
        int             pick, sel;
        alloc_result_t  tr;

        reset_table();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[n]) begin
            tr.addr   = dir_rows[n].exp_addr;
            tr.status = dir_rows[n].exp_status;
            send_request(dir_rows[n].cmd, dir_rows[n].size, dir_rows[n].addr,
                         dir_rows[n].typed, tr);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            // small allocations fill the table up to full
            if (pick < 50) begin
                c  = ffsa_pkg::CMD_ALLOC;
                sel = $urandom_range(0, 19);
                sz = (sel == 0) ? 13'($urandom) :
                     (sel == 1) ? 13'($urandom_range(0, POOL)) :
                                  13'($urandom_range(1, 96));
                ad = 12'($urandom);
            end else if (pick < 92 && live_cnt > 0) begin
                c   = ffsa_pkg::CMD_RELEASE;
                sel = $urandom_range(0, live_cnt - 1);
                ad  = live_addr[sel];
                sz  = 13'($urandom_range(1, 96));
                // whole release removes it from the live list
                for (int k = 0; k < seg_num; k++)
                    if (seg_busy[k] && seg_base[k] == ad) begin
                        if ($urandom_range(0, 1)) sz = seg_len[k];
                        else if (seg_len[k] > 1) sz = 13'($urandom_range(1, seg_len[k] - 1));
                        if ($urandom_range(0, 15) == 0) sz = seg_len[k] + 1;
                        if (sz == seg_len[k]) begin
                            live_addr[sel] = live_addr[live_cnt - 1];
                            live_cnt--;
                        end else if (sz < seg_len[k]) begin
                            live_addr[sel] = ad + sz[11:0];
                        end
                    end
            end else begin
                c  = ffsa_pkg::CMD_RELEASE;
                sz = 13'($urandom);
                ad = 12'($urandom);
            end
            tr = '0;
            send_request(c, sz, ad, 1'b0, tr);
            // refresh the live list from the shadow table now and then
            if ($urandom_range(0, 31) == 0) begin
                live_cnt = 0;
                for (int k = 0; k < seg_num; k++)
                    if (seg_busy[k]) begin
                        live_addr[live_cnt] = seg_base[k];
                        live_cnt++;
                    end
            end
        end
        s_tvalid <= 1'b0;

        while (exp_rd != exp_wr) @(posedge aclk);
        repeat (2 * MAX_SEG + 20) @(posedge aclk);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ffsa_pkg.sv
sv/ffsa_ram.sv
sv/first_fit_segment_allocator_unit.sv
tb/tb_first_fit_segment_allocator_unit.sv
